// ----- sv/ippcl_pkg.sv -----
`timescale 1ns / 1ps
// ippcl_pkg: shared types, codes and constants of the ip prefix class lookup unit
// used by the channel interfaces and the top level; depends on nothing else

package ippcl_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int ADDR_W  = 32;
   localparam int LEN_W   = 6;
   localparam int CLASS_W = 7;
   localparam int CSR_W   = 7;

   localparam logic [LEN_W-1:0]   MAX_LEN          = 6'd32;
   localparam logic [CLASS_W-1:0] DEFAULT_TYPE_RST = 7'd1;
   localparam logic [LEN_W-1:0]   SHORTEST_LEN_RST = 6'd8;
   localparam logic [LEN_W-1:0]   LONGEST_LEN_RST  = 6'd23;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_CLEAR  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      CSR_DEFAULT_TYPE = 2'd0,
      CSR_SHORTEST_LEN = 2'd1,
      CSR_LONGEST_LEN  = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  key;
      logic [LEN_W-1:0]   len;
      logic [CLASS_W-1:0] nclass;
   } entry_type;

   // network mask for a prefix length of 0 to 32
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      prefix_mask = ~({ADDR_W{1'b1}} >> len);
   endfunction

endpackage

// ----- sv/ippcl_req_if.sv -----
`timescale 1ns / 1ps
// ippcl_req_if, ippcl_rsp_if, ippcl_csr_if: valid/ready channels of the lookup unit
// depends on ippcl_pkg for field widths

interface ippcl_req_if import ippcl_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [ADDR_W-1:0]  address;
   logic [LEN_W-1:0]   prefix_len;
   logic [CLASS_W-1:0] net_class;

   modport source (output valid, action, address, prefix_len, net_class, input ready);
   modport sink   (input valid, action, address, prefix_len, net_class, output ready);
endinterface

interface ippcl_rsp_if import ippcl_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CLASS_W-1:0] result_class;
   logic               matched;
   logic               status;

   modport source (output valid, result_class, matched, status, input ready);
   modport sink   (input valid, result_class, matched, status, output ready);
endinterface

interface ippcl_csr_if import ippcl_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       index;
   logic [CSR_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/ip_prefix_class_lookup_unit.sv -----
`timescale 1ns / 1ps
// ip_prefix_class_lookup_unit: insert and lookup transactions scan the N stored entries (0 to 1024)
// before the response handshake: one registered table read per cycle, one compare unit; an insert
// stops at its own key. Clear and unused actions go straight to the response. One transaction at
// a time, the next accepted in the cycle after the response handshake. Reset empties the table
// through the fill count (no clearing pass) and loads the register defaults. Depends on ippcl_pkg
// and the channel interfaces.

module ip_prefix_class_lookup_unit import ippcl_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   ippcl_req_if.sink   req_chan,
   ippcl_rsp_if.source rsp_chan,
   ippcl_csr_if.sink   csr_chan
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [CLASS_W-1:0] default_type_ff;
   logic [LEN_W-1:0]   shortest_len_ff, longest_len_ff;

   logic [1:0]         action_ff;
   logic [ADDR_W-1:0]  address_ff;
   logic [LEN_W-1:0]   plen_ff;
   logic [CLASS_W-1:0] nclass_ff;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic               found_ff, found_in;
   logic [LEN_W-1:0]   best_len_ff, best_len_in;
   logic [CLASS_W-1:0] best_class_ff, best_class_in;

   logic [CLASS_W-1:0] rsp_class_ff, rsp_class_in;
   logic               rsp_matched_ff, rsp_matched_in;
   logic               rsp_status_ff, rsp_status_in;

   entry_type          entry_mem_ff [TABLE_DEPTH];
   entry_type          rd_data_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;

   logic               req_acc, rsp_acc, csr_acc;
   logic [LEN_W-1:0]   lo_len, hi_len;
   logic               scan_done, cand;

   assign req_acc = req_chan.valid & req_chan.ready;
   assign rsp_acc = rsp_chan.valid & rsp_chan.ready;
   assign csr_acc = csr_chan.valid & csr_chan.ready;

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = (state_ff == ST_RESP);
   assign rsp_chan.result_class = rsp_class_ff;
   assign rsp_chan.matched      = rsp_matched_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign csr_chan.ready        = 1'b1;

   // length registers above 32 behave as 32
   assign lo_len = (shortest_len_ff > MAX_LEN) ? MAX_LEN : shortest_len_ff;
   assign hi_len = (longest_len_ff > MAX_LEN) ? MAX_LEN : longest_len_ff;

   assign scan_done = !pend_ff && (scan_idx_ff == count_ff);

   // keys are unique, so the shortest stored prefix covering the address wins
   assign cand = (rd_data_ff.len >= lo_len) && (rd_data_ff.len <= hi_len) &&
                 (rd_data_ff.key == (address_ff & prefix_mask(rd_data_ff.len)));

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      scan_idx_in    = scan_idx_ff;
      pend_in        = 1'b0;
      pend_idx_in    = pend_idx_ff;
      found_in       = found_ff;
      best_len_in    = best_len_ff;
      best_class_in  = best_class_ff;
      rsp_class_in   = rsp_class_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_status_in  = rsp_status_ff;
      mem_we         = 1'b0;
      mem_waddr      = pend_idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               rsp_class_in   = '0;
               rsp_matched_in = 1'b0;
               rsp_status_in  = 1'b0;
               case (req_chan.action)
                  ACT_INSERT, ACT_LOOKUP: begin
                     state_in    = ST_SCAN;
                     scan_idx_in = '0;
                     found_in    = 1'b0;
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                     state_in = ST_RESP;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end

         ST_SCAN: begin
            // issue the next read while the previous one is compared
            if (scan_idx_ff != count_ff) begin
               scan_idx_in = scan_idx_ff + CNT_W'(1);
               pend_in     = 1'b1;
               pend_idx_in = scan_idx_ff[IDX_W-1:0];
            end

            if (action_ff == ACT_INSERT) begin
               if (pend_ff && (rd_data_ff.key == address_ff)) begin
                  mem_we    = 1'b1;
                  mem_waddr = pend_idx_ff;
                  pend_in   = 1'b0;
                  state_in  = ST_RESP;
               end else if (scan_done) begin
                  if (count_ff != CNT_W'(TABLE_DEPTH)) begin
                     mem_we    = 1'b1;
                     mem_waddr = count_ff[IDX_W-1:0];
                     count_in  = count_ff + CNT_W'(1);
                  end else begin
                     rsp_status_in = 1'b1;
                  end
                  state_in = ST_RESP;
               end
            end else begin
               if (pend_ff && cand && (!found_ff || (rd_data_ff.len < best_len_ff))) begin
                  found_in      = 1'b1;
                  best_len_in   = rd_data_ff.len;
                  best_class_in = rd_data_ff.nclass;
               end
               if (scan_done) begin
                  rsp_matched_in = found_ff;
                  rsp_class_in   = (found_ff && (best_class_ff != '0)) ? best_class_ff
                                                                       : default_type_ff;
                  state_in       = ST_RESP;
               end
            end
         end

         ST_RESP: begin
            if (rsp_acc) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         scan_idx_ff     <= '0;
         pend_ff         <= 1'b0;
         found_ff        <= 1'b0;
         default_type_ff <= DEFAULT_TYPE_RST;
         shortest_len_ff <= SHORTEST_LEN_RST;
         longest_len_ff  <= LONGEST_LEN_RST;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         scan_idx_ff <= scan_idx_in;
         pend_ff     <= pend_in;
         found_ff    <= found_in;
         if (csr_acc) begin
            case (csr_chan.index)
               CSR_DEFAULT_TYPE: default_type_ff <= csr_chan.data;
               CSR_SHORTEST_LEN: shortest_len_ff <= csr_chan.data[LEN_W-1:0];
               CSR_LONGEST_LEN:  longest_len_ff  <= csr_chan.data[LEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff    <= pend_idx_in;
      best_len_ff    <= best_len_in;
      best_class_ff  <= best_class_in;
      rsp_class_ff   <= rsp_class_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_status_ff  <= rsp_status_in;
      if (req_acc) begin
         action_ff  <= req_chan.action;
         address_ff <= req_chan.address;
         plen_ff    <= req_chan.prefix_len;
         nclass_ff  <= req_chan.net_class;
      end
   end

   // entry memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[mem_waddr] <= '{key: address_ff, len: plen_ff, nclass: nclass_ff};
      end
      rd_data_ff <= entry_mem_ff[scan_idx_ff[IDX_W-1:0]];
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("fill count beyond table depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_idx_ff <= count_ff))
      else $error("scan index past fill count");

   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_SCAN))
      else $error("read pending outside scan");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_chan.action == ACT_CLEAR)) |=> (count_ff == '0))
      else $error("clear left entries");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status) |-> (count_ff == CNT_W'(TABLE_DEPTH)))
      else $error("insert dropped while table not full");
`endif

endmodule

// ----- test/tb_ip_prefix_class_lookup_unit.sv -----
`timescale 1ns / 1ps
// tb_ip_prefix_class_lookup_unit: self-checking bench for the prefix class lookup unit
// drives insert, lookup, clear and unused transactions with random idling and checks every response
// against a table kept in the bench; depends on ippcl_pkg and the channel interfaces

module tb_ip_prefix_class_lookup_unit;
   import ippcl_pkg::*;

   localparam logic [1:0] ACT_UNUSED      = 2'd3;
   localparam logic [1:0] CSR_UNUSED      = 2'd3;
   localparam int         CYCLE_LIMIT     = 12_000_000;
   localparam int         HOLD_OFF_CYCLES = 400;
   localparam int         RANDOM_PHASES   = 6;
   localparam int         PHASE_ITEMS     = 25;
   localparam int         TABLE_KEEP      = 40;

   typedef struct packed {
      logic [1:0]         action;
      logic [ADDR_W-1:0]  address;
      logic [LEN_W-1:0]   prefix_len;
      logic [CLASS_W-1:0] net_class;
   } request_type;

   typedef struct packed {
      logic [CLASS_W-1:0] result_class;
      logic               matched;
      logic               status;
   } answer_type;

   logic clock;
   logic reset;

   ippcl_req_if req_if();
   ippcl_rsp_if rsp_if();
   ippcl_csr_if csr_if();

   ip_prefix_class_lookup_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // bench copy of the network table, keyed by stored address
   logic [LEN_W-1:0]   net_len_of   [bit [ADDR_W-1:0]];
   logic [CLASS_W-1:0] net_class_of [bit [ADDR_W-1:0]];
   logic [CLASS_W-1:0] mdl_default_type = DEFAULT_TYPE_RST;
   logic [LEN_W-1:0]   mdl_shortest     = SHORTEST_LEN_RST;
   logic [LEN_W-1:0]   mdl_longest      = LONGEST_LEN_RST;

   request_type table_requests[$];
   answer_type  class_answers_due[$];

   // networks inserted by the generator, used to aim lookups at stored entries
   logic [ADDR_W-1:0] gen_keys[$];
   logic [LEN_W-1:0]  gen_lens[$];

   int  items_queued      = 0;
   int  items_accepted    = 0;
   int  mismatches        = 0;
   int  cycle_count       = 0;
   int  long_stalls_asked = 0;
   int  long_stalls_done  = 0;
   int  req_gap           = 0;
   int  rsp_stall         = 0;
   bit  req_taken         = 1'b0;
   bit  idle_on           = 1'b1;

   always #6 clock = ~clock;

   function automatic logic [ADDR_W-1:0] net_mask(input int len);
      if (len <= 0)
         return '0;
      else if (len >= 32)
         return '1;
      else
         return ~(32'hFFFF_FFFF >> len);
   endfunction

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
      return (len > MAX_LEN) ? MAX_LEN : len;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   // applies one transaction to the bench table and returns the response it must produce
   function automatic answer_type answer_request(input request_type rq);
      answer_type        ans;
      logic [LEN_W-1:0]  lo;
      logic [LEN_W-1:0]  hi;
      logic [ADDR_W-1:0] probe;
      ans = '0;
      case (rq.action)
         ACT_INSERT: begin
            if (net_len_of.exists(rq.address) || net_len_of.num() < TABLE_DEPTH) begin
               net_len_of[rq.address]   = rq.prefix_len;
               net_class_of[rq.address] = rq.net_class;
            end else begin
               ans.status = 1'b1;
            end
         end
         ACT_LOOKUP: begin
            lo = clamp_len(mdl_shortest);
            hi = clamp_len(mdl_longest);
            ans.result_class = mdl_default_type;
            for (int len = lo; len <= hi; len++) begin
               probe = rq.address & net_mask(len);
               if (net_len_of.exists(probe) && net_len_of[probe] == len) begin
                  ans.matched = 1'b1;
                  if (net_class_of[probe] != '0)
                     ans.result_class = net_class_of[probe];
                  break;
               end
            end
         end
         ACT_CLEAR: begin
            net_len_of.delete();
            net_class_of.delete();
         end
         default: ;
      endcase
      return ans;
   endfunction

   // sampling at the rising edge: configuration, responses, then accepted requests
   always @(posedge clock) begin : monitor
      request_type rq;
      answer_type  seen;
      answer_type  want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         cycle_count++;
         req_taken = req_if.valid && req_if.ready;
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_DEFAULT_TYPE: mdl_default_type = csr_if.data[CLASS_W-1:0];
               CSR_SHORTEST_LEN: mdl_shortest     = csr_if.data[LEN_W-1:0];
               CSR_LONGEST_LEN:  mdl_longest      = csr_if.data[LEN_W-1:0];
               default: ;
            endcase
         end
         if (rsp_if.valid && rsp_if.ready) begin
            seen.result_class = rsp_if.result_class;
            seen.matched      = rsp_if.matched;
            seen.status       = rsp_if.status;
            if (class_answers_due.size() == 0) begin
               $error("response with no transaction outstanding: class %0d matched %0d status %0d",
                      seen.result_class, seen.matched, seen.status);
               mismatches++;
            end else begin
               want = class_answers_due.pop_front();
               if (seen.result_class !== want.result_class) begin
                  $error("result_class mismatch: expected %0d, actual %0d",
                         want.result_class, seen.result_class);
                  mismatches++;
               end
               if (seen.matched !== want.matched) begin
                  $error("matched mismatch: expected %0d, actual %0d", want.matched, seen.matched);
                  mismatches++;
               end
               if (seen.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d", want.status, seen.status);
                  mismatches++;
               end
            end
         end
         if (req_taken) begin
            rq.action     = req_if.action;
            rq.address    = req_if.address;
            rq.prefix_len = req_if.prefix_len;
            rq.net_class  = req_if.net_class;
            class_answers_due.push_back(answer_request(rq));
            items_accepted++;
         end
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("ip_prefix_class_lookup_unit verification failed");
            $finish;
         end
      end
   end

   // request side: offer the next transaction once the current one is taken
   always @(negedge clock) begin : req_driver
      request_type rq;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_taken) begin
         // hold the offered transaction
      end else if (req_gap > 0) begin
         req_if.valid <= 1'b0;
         req_gap--;
      end else if (table_requests.size() > 0) begin
         rq = table_requests.pop_front();
         req_if.action     <= rq.action;
         req_if.address    <= rq.address;
         req_if.prefix_len <= rq.prefix_len;
         req_if.net_class  <= rq.net_class;
         req_if.valid      <= 1'b1;
         req_gap = idle_on ? pick_gap() : 0;
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // response side: random stalls plus the occasional long hold-off
   always @(negedge clock) begin : rsp_driver
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (long_stalls_done != long_stalls_asked) begin
         long_stalls_done++;
         rsp_stall = HOLD_OFF_CYCLES;
         rsp_if.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_stall = pick_gap();
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic queue_request(input logic [1:0] action, input logic [ADDR_W-1:0] address,
                                input logic [LEN_W-1:0] plen, input logic [CLASS_W-1:0] nclass);
      request_type rq;
      rq.action     = action;
      rq.address    = address;
      rq.prefix_len = plen;
      rq.net_class  = nclass;
      table_requests.push_back(rq);
      items_queued++;
   endtask

   task automatic queue_clear();
      queue_request(ACT_CLEAR, $urandom, LEN_W'($urandom_range(0, 63)),
                    CLASS_W'($urandom_range(0, 127)));
      gen_keys.delete();
      gen_lens.delete();
   endtask

   task automatic wait_until_idle();
      while (items_accepted != items_queued || class_answers_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_if.index <= idx;
      csr_if.data  <= value;
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // length registers get a random top bit, which the block must drop
   task automatic set_config(input int dflt, input int lo, input int hi);
      csr_write(CSR_DEFAULT_TYPE, CSR_W'(dflt));
      csr_write(CSR_SHORTEST_LEN, {1'($urandom_range(0, 1)), LEN_W'(lo)});
      csr_write(CSR_LONGEST_LEN, {1'($urandom_range(0, 1)), LEN_W'(hi)});
   endtask

   task automatic run_random_phase(input int count);
      int                n;
      int                r;
      int                pick;
      int                stored;
      logic [LEN_W-1:0]  lo;
      logic [LEN_W-1:0]  hi;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] key;
      logic [CLASS_W-1:0] cls;
      n = 0;
      stored = 0;
      lo = clamp_len(mdl_shortest);
      hi = clamp_len(mdl_longest);
      while (n < count) begin
         r = $urandom_range(0, 99);
         // keep the table small so each transaction stays short
         if (stored >= TABLE_KEEP || r < 3) begin
            queue_clear();
            stored = 0;
            n++;
         end else if (r < 38) begin
            len = (lo <= hi) ? LEN_W'($urandom_range(lo, hi)) : LEN_W'($urandom_range(0, 32));
            cls = ($urandom_range(0, 9) == 0) ? '0 : CLASS_W'($urandom_range(1, 127));
            if (gen_keys.size() > 0 && $urandom_range(0, 9) == 0) begin
               // overwrite of a stored network
               pick = $urandom_range(0, gen_keys.size() - 1);
               key = gen_keys[pick];
            end else begin
               key = $urandom & net_mask(len);
               gen_keys.push_back(key);
               gen_lens.push_back(len);
               stored++;
            end
            queue_request(ACT_INSERT, key, len, cls);
            n++;
         end else if (r < 80) begin
            if (gen_keys.size() > 0 && $urandom_range(0, 9) < 7) begin
               pick = $urandom_range(0, gen_keys.size() - 1);
               key = gen_keys[pick] | ($urandom & ~net_mask(gen_lens[pick]));
            end else begin
               key = $urandom;
            end
            queue_request(ACT_LOOKUP, key, LEN_W'($urandom_range(0, 63)),
                          CLASS_W'($urandom_range(0, 127)));
            n++;
         end else if (r < 90) begin
            // malformed insert: unmasked key, any length
            queue_request(ACT_INSERT, $urandom, LEN_W'($urandom_range(0, 63)),
                          CLASS_W'($urandom_range(0, 127)));
            stored++;
            n++;
         end else if (r < 93) begin
            queue_request(ACT_UNUSED, $urandom, LEN_W'($urandom_range(0, 63)),
                          CLASS_W'($urandom_range(0, 127)));
         end else begin
            queue_request(ACT_LOOKUP, $urandom, LEN_W'($urandom_range(0, 63)),
                          CLASS_W'($urandom_range(0, 127)));
            n++;
         end
      end
   endtask

   initial begin : stimulus
      int k;
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid      = 1'b0;
      req_if.action     = '0;
      req_if.address    = '0;
      req_if.prefix_len = '0;
      req_if.net_class  = '0;
      rsp_if.ready      = 1'b0;
      csr_if.valid      = 1'b0;
      csr_if.index      = '0;
      csr_if.data       = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults after reset
      queue_request(ACT_LOOKUP, 32'h0000_0000, 6'd0, 7'd0);
      queue_request(ACT_INSERT, 32'h0A00_0000, 6'd8, 7'd5);
      queue_request(ACT_LOOKUP, 32'h0A01_0203, 6'd63, 7'd127);
      queue_request(ACT_INSERT, 32'h0B01_0000, 6'd16, 7'd0);
      queue_request(ACT_LOOKUP, 32'h0B01_0909, 6'd0, 7'd0);
      // key stored with a length outside the searched range
      queue_request(ACT_INSERT, 32'h0C00_0000, 6'd24, 7'd9);
      queue_request(ACT_LOOKUP, 32'h0C00_0005, 6'd0, 7'd0);
      queue_request(ACT_INSERT, 32'hFFFF_FFFF, 6'd63, 7'd127);
      queue_request(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0, 7'd0);
      queue_request(ACT_UNUSED, 32'hFFFF_FFFF, 6'd63, 7'd127);
      queue_request(ACT_INSERT, 32'h0A00_0000, 6'd8, 7'd127);
      queue_request(ACT_LOOKUP, 32'h0A09_0909, 6'd0, 7'd0);
      queue_request(ACT_CLEAR, 32'hFFFF_FFFF, 6'd63, 7'd127);
      queue_request(ACT_LOOKUP, 32'h0A09_0909, 6'd0, 7'd0);
      queue_request(ACT_INSERT, 32'h0000_0000, 6'd0, 7'd3);
      queue_request(ACT_INSERT, 32'hFFFF_FFFF, 6'd32, 7'd64);
      wait_until_idle();

      // zero length masks everything to the all-zero key
      set_config(0, 0, 32);
      queue_request(ACT_LOOKUP, 32'h0102_0304, 6'd0, 7'd0);
      queue_request(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0, 7'd0);
      wait_until_idle();

      // length registers above 32 behave as 32
      set_config(127, 63, 63);
      queue_request(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0, 7'd0);
      queue_request(ACT_LOOKUP, 32'h0000_0000, 6'd0, 7'd0);
      wait_until_idle();

      // shortest above longest, and a write to a register that does not exist
      set_config(5, 20, 10);
      csr_write(CSR_UNUSED, 7'h7F);
      queue_request(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0, 7'd0);
      queue_request(ACT_CLEAR, 32'h0000_0000, 6'd0, 7'd0);
      wait_until_idle();

      // fill the table to the last slot, then overflow it
      set_config(1, 24, 24);
      idle_on = 1'b0;
      for (k = 0; k < TABLE_DEPTH; k++)
         queue_request(ACT_INSERT, 32'h0A00_0000 | (k << 8), 6'd24, CLASS_W'(k));
      queue_request(ACT_INSERT, 32'h0B00_0000, 6'd24, 7'd77);
      queue_request(ACT_INSERT, 32'h0A00_0500, 6'd24, 7'd99);
      queue_request(ACT_LOOKUP, 32'h0A00_05FF, 6'd0, 7'd0);
      queue_request(ACT_LOOKUP, 32'h0B00_0000, 6'd0, 7'd0);
      queue_request(ACT_CLEAR, 32'h0000_0000, 6'd0, 7'd0);
      queue_request(ACT_LOOKUP, 32'h0A00_0100, 6'd0, 7'd0);
      wait_until_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: set_config($urandom_range(0, 127), 8, 23);
            1: set_config($urandom_range(0, 127), 0, 32);
            2: begin
               k = $urandom_range(1, 32);
               set_config($urandom_range(0, 127), k, $urandom_range(k, 32));
            end
            3: set_config($urandom_range(0, 127), $urandom_range(10, 24), $urandom_range(33, 63));
            4: set_config($urandom_range(0, 127), $urandom_range(0, 63), $urandom_range(0, 63));
            default: set_config(127, 1, 32);
         endcase
         idle_on = (p != 4);
         queue_clear();
         run_random_phase(PHASE_ITEMS);
         // long receiver hold-off while requests keep coming
         if (p == 0)
            long_stalls_asked++;
         wait_until_idle();
      end

      repeat (TABLE_DEPTH + 16) @(posedge clock);
      if (mismatches == 0)
         $display("ip_prefix_class_lookup_unit verification clean");
      else
         $display("ip_prefix_class_lookup_unit verification failed");
      $finish;
   end

endmodule
